// ----- rtl/core/rrss_pkg.sv -----
package rrss_pkg;

	// table size and derived widths
	localparam int TASK_SLOTS = 16;
	localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

	// fixed field widths
	localparam int TICK_W     = 32;
	localparam int SCHED_W    = 16;
	localparam int RUN_W      = 4;
	localparam int COUNT_W    = 5;
	localparam int FUNC_W     = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USED_W = RUN_W + COUNT_W + 1 + 1 + SCHED_W;

	// input item kinds
	typedef enum logic [FUNC_W-1:0] {
		FUNC_REG   = 2'd0,
		FUNC_SLEEP = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// controls shared along the chain
	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  wr_idx;
		logic [TICK_W-1:0] wr_data;
		logic              dec;
		logic              load;
		logic [IDX_W-1:0]  start_idx;
		logic              shift;
		logic [CNT_W-1:0]  n;
	} chain_ctl_t;

	// controls seen by one cell
	typedef struct packed {
		logic wr;
		logic dec;
		logic active;
		logic load;
		logic tok_set;
		logic shift;
		logic last;
	} cell_ctl_t;

endpackage

// ----- rtl/core/rrss_cell.sv -----
module rrss_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rrss_pkg::cell_ctl_t        ctl,
	input  logic [rrss_pkg::TICK_W-1:0] wr_data,
	input  logic                       tok_in,
	output logic                       tok_out,
	output logic                       wrap_out,
	output logic                       hit
);
	import rrss_pkg::*;

	logic [TICK_W-1:0] cnt_q;
	logic              tok_q;

	// sleep counter: load, or count down while nonzero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.wr) begin
			cnt_q <= wr_data;
		end else if (ctl.dec && ctl.active && (cnt_q != '0)) begin
			cnt_q <= cnt_q - TICK_W'(1);
		end
	end

	// search token, handed to the next cell each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.load) begin
			tok_q <= ctl.tok_set;
		end else if (ctl.shift) begin
			tok_q <= tok_in;
		end
	end

	assign tok_out  = tok_q;
	assign wrap_out = tok_q & ctl.last;
	assign hit      = tok_q & (cnt_q == '0);

endmodule

// ----- rtl/core/rrss_chain.sv -----
module rrss_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrss_pkg::chain_ctl_t          ctl,
	output logic                          hit_any,
	output logic [rrss_pkg::IDX_W-1:0]    hit_idx
);
	import rrss_pkg::*;

	cell_ctl_t              cctl [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]  tok;
	logic [TASK_SLOTS-1:0]  wrap;
	logic [TASK_SLOTS-1:0]  hit;
	logic                   wrap_any;

	// per-cell decode of the shared controls
	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			cctl[i].wr      = ctl.wr && (ctl.wr_idx == IDX_W'(i));
			cctl[i].dec     = ctl.dec;
			cctl[i].active  = CNT_W'(i) < ctl.n;
			cctl[i].load    = ctl.load;
			cctl[i].tok_set = ctl.start_idx == IDX_W'(i);
			cctl[i].shift   = ctl.shift;
			cctl[i].last    = (CNT_W'(i) + CNT_W'(1)) == ctl.n;
		end
	end

	assign wrap_any = |wrap;

	// ring of cells: token goes to the neighbor, last active cell wraps to cell zero
	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		logic tin;
		if (g == 0) begin : g_head
			assign tin = wrap_any;
		end else begin : g_body
			assign tin = tok[g-1] & ~wrap[g-1];
		end
		rrss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cctl[g]),
			.wr_data  (ctl.wr_data),
			.tok_in   (tin),
			.tok_out  (tok[g]),
			.wrap_out (wrap[g]),
			.hit      (hit[g])
		);
	end

	// token is one-hot, so at most one hit
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit_any = |hit;

endmodule

// ----- rtl/core/round_robin_sleep_scheduler.sv -----
// Round-robin task scheduler with one sleep counter per registered task.
// Input channel s_*: s_tuser carries the item kind (register, sleep, tick),
// s_tdata carries the sleep length used by sleep words.
// Output channel m_*: one result word per input word, giving the running
// task, the task count, the none-ready and rejected flags and the tick count.
// Register, sleep and unused-kind words go from accept to S_OUT, then to the output register.
// A tick word decrements the nonzero counters of registered tasks at accept, then a token walks the ring
// of counter cells one cell per cycle from the task after the running one;
// it stops at the first ready task or once every registered task is checked;
// with no task registered it sets none-ready at once and skips the walk.
// One word is handled at a time; the next is taken once the result has
// moved into the output register, so input is accepted while a result
// waits. When the receiver stalls, the result is held and a later result
// waits in its final state until the output register frees up.
// Reset clears all counters, the task table, the running task and the tick
// count, and empties the output register.
module round_robin_sleep_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rrss_pkg::IN_DATA_W-1:0]    s_tdata,  // [31:0] ticks
	input  logic [rrss_pkg::FUNC_W-1:0]       s_tuser,  // [1:0] func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] running_task, [8:4] task_count, [9] none_ready, [10] rejected,
	// [26:11] sched_count, [31:27] zero
	output logic [rrss_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import rrss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SRCH = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cur_q;
	logic [CNT_W-1:0]   count_q;
	logic [SCHED_W-1:0] sched_q;
	logic [CNT_W-1:0]   step_q;
	logic               none_q;
	logic               rej_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	chain_ctl_t         ctl;
	logic               hit_any;
	logic [IDX_W-1:0]   hit_idx;
	logic               acc;
	func_t              func;
	logic [CNT_W-1:0]   nxt_cur;
	logic               full;
	logic               out_free;

	assign acc      = s_tvalid && s_tready;
	assign func     = func_t'(s_tuser);
	assign s_tready = state_q == S_IDLE;
	assign full     = count_q >= CNT_W'(TASK_SLOTS);
	assign nxt_cur  = CNT_W'(cur_q) + CNT_W'(1);
	assign out_free = !out_valid_q || m_tready;

	// chain controls
	always_comb begin
		ctl           = '0;
		ctl.n         = count_q;
		ctl.start_idx = (nxt_cur == count_q) ? '0 : nxt_cur[IDX_W-1:0];
		ctl.wr_data   = s_tdata[TICK_W-1:0];
		ctl.wr_idx    = cur_q;
		if (acc) begin
			case (func)
				FUNC_REG: begin
					ctl.wr      = !full;
					ctl.wr_idx  = count_q[IDX_W-1:0];
					ctl.wr_data = '0;
				end
				FUNC_SLEEP: begin
					ctl.wr = 1'b1;
				end
				FUNC_TICK: begin
					ctl.dec  = count_q != '0;
					ctl.load = count_q != '0;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_SRCH && !hit_any && step_q != count_q) begin
			ctl.shift = 1'b1;
		end
	end

	rrss_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.hit_any (hit_any),
		.hit_idx (hit_idx)
	);

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			count_q <= '0;
			sched_q <= '0;
			step_q  <= '0;
			none_q  <= 1'b0;
			rej_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						none_q  <= 1'b0;
						rej_q   <= 1'b0;
						step_q  <= CNT_W'(1);
						state_q <= S_OUT;
						case (func)
							FUNC_REG: begin
								if (full) begin
									rej_q <= 1'b1;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							FUNC_TICK: begin
								sched_q <= sched_q + SCHED_W'(1);
								if (count_q == '0) begin
									none_q <= 1'b1;
								end else begin
									state_q <= S_SRCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SRCH: begin
					if (hit_any) begin
						cur_q   <= hit_idx;
						state_q <= S_OUT;
					end else if (step_q == count_q) begin
						none_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_data_q <= OUT_DATA_W'({sched_q, rej_q, none_q,
				COUNT_W'(count_q), RUN_W'(cur_q)});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
